[src/ddr_pkg.sv]
// Shared types, constants and the CORDIC arctangent table for dead reckoning.
`default_nettype none

package ddr_pkg;

	localparam logic [15:0] RADIUS_RESET = 16'd4494;
	localparam logic [15:0] STEP_RESET   = 16'd6554;

	localparam int ANGLE_BITS_DEFAULT = 16;
	localparam int FIFO_DEPTH_DEFAULT = 2;

	localparam int CORDIC_ITERS = 16;
	localparam logic signed [33:0] CORDIC_X0    = 34'sd652032874;
	localparam logic signed [31:0] QUARTER_TURN = 32'sd1073741824;

	// Register indexes on the configuration port.
	localparam logic REG_WHEEL_RADIUS = 1'b0;
	localparam logic REG_STEP_SIZE    = 1'b1;

	localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861
	};

	typedef struct packed {
		logic signed [16:0] wheel_sum;
		logic [15:0]        heading;
		logic               clear_pos;
	} ddr_req_t;

endpackage

`default_nettype wire

[src/ddr_fifo.sv]
// Small flip-flop request queue between the front and back parts.
`default_nettype none

module ddr_fifo #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output logic                  full,
	output logic                  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop)) else $error("request pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("request popped from empty queue");

endmodule

`default_nettype wire

[src/ddr_front.sv]
// Front part: accepts ticks, tracks the run flag and forms the queued request.
`default_nettype none

module ddr_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] left_wheel_rate,
	input  wire logic signed [15:0] right_wheel_rate,
	input  wire logic [15:0]        heading,
	input  wire logic               run_flag,
	input  wire logic               queue_full,
	output logic                    push,
	output ddr_pkg::ddr_req_t       req
);
	import ddr_pkg::*;

	logic running_q;

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		req.wheel_sum = {left_wheel_rate[15], left_wheel_rate}
			+ {right_wheel_rate[15], right_wheel_rate};
		req.heading   = heading;
		// A rising run flag clears the position before this tick's step.
		req.clear_pos = run_flag && !running_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
		end else if (push) begin
			running_q <= run_flag;
		end
	end

endmodule

`default_nettype wire

[src/ddr_back.sv]
// Back part: CORDIC sine and cosine, step distance, and position integration.
`default_nettype none

module ddr_back #(
	parameter int ANGLE_BITS = ddr_pkg::ANGLE_BITS_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ddr_pkg::ddr_req_t  req,
	input  wire logic               req_avail,
	output logic                    req_pop,
	input  wire logic [15:0]        wheel_radius,
	input  wire logic [15:0]        step_size,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic [31:0]             sequence_res
);
	import ddr_pkg::*;

	localparam int KEEP = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
	localparam logic [15:0] HMASK = 16'hFFFF << (16 - KEEP);

	typedef enum logic [2:0] {
		S_IDLE, S_ROT, S_RND, S_MULX, S_MULY, S_DELY, S_DONE
	} state_t;

	state_t             state_q;
	logic [3:0]         cnt_q;
	logic signed [33:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic               flip_q;
	logic               clear_q;
	logic signed [16:0] sum_q;
	logic signed [33:0] prod1_q;
	logic signed [40:0] d_q;
	logic signed [16:0] c_q, s_q;
	logic signed [33:0] pl_q;
	logic signed [41:0] ph_q;
	logic signed [26:0] dx_q, dy_q;
	logic signed [31:0] new_x_q;
	logic               out_valid_q;
	logic signed [31:0] pos_x_q, pos_y_q;
	logic [31:0]        seq_q;

	logic [15:0]        head_m;
	logic signed [31:0] z_start;
	logic               wrap;
	logic signed [33:0] sx, sy;
	logic signed [33:0] xr, yr;
	logic signed [16:0] c_new, s_new;
	logic signed [33:0] p1;
	logic signed [50:0] p2;
	logic signed [16:0] dl;
	logic signed [24:0] dh;
	logic signed [16:0] opnd;
	logic signed [33:0] pl;
	logic signed [41:0] ph;
	logic signed [58:0] acc;
	logic signed [26:0] delta;
	logic signed [31:0] base_x, base_y;
	logic signed [31:0] sat_x, sat_y;
	logic               commit;

	function automatic logic signed [31:0] sat_add(logic signed [31:0] b,
		logic signed [26:0] d);
		logic signed [32:0] s;
		s = {b[31], b} + {{6{d[26]}}, d};
		if (s[32] != s[31]) begin
			sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sat_add = s[31:0];
		end
	endfunction

	always_comb begin
		head_m  = req.heading & HMASK;
		z_start = {head_m, 16'h0000};
		// Angles beyond a quarter turn are rotated by a half turn and the result negated.
		wrap    = (z_start > QUARTER_TURN) || (z_start < -QUARTER_TURN);
		if (wrap) begin
			z_start[31] = ~z_start[31];
		end

		sx = x_q >>> cnt_q;
		sy = y_q >>> cnt_q;

		xr    = x_q + 34'sd16384;
		yr    = y_q + 34'sd16384;
		c_new = flip_q ? -xr[31:15] : xr[31:15];
		s_new = flip_q ? -yr[31:15] : yr[31:15];

		p1 = sum_q * $signed({1'b0, wheel_radius});
		p2 = prod1_q * $signed({1'b0, step_size});

		// The 41-bit distance is multiplied in a low and a high partial product.
		dl   = $signed({1'b0, d_q[15:0]});
		dh   = d_q[40:16];
		opnd = (state_q == S_MULX) ? c_q : s_q;
		pl   = dl * opnd;
		ph   = dh * opnd;

		acc   = ({{17{ph_q[41]}}, ph_q} <<< 16) + {{25{pl_q[33]}}, pl_q}
			+ 59'sd2147483648;
		delta = acc[58:32];

		base_x = clear_q ? 32'sd0 : pos_x_q;
		base_y = clear_q ? 32'sd0 : pos_y_q;
		sat_x  = sat_add(base_x, dx_q);
		sat_y  = sat_add(base_y, dy_q);

		req_pop = (state_q == S_IDLE) && req_avail;
		commit  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			seq_q       <= '0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_avail) begin
						x_q     <= CORDIC_X0;
						y_q     <= '0;
						z_q     <= z_start;
						flip_q  <= wrap;
						clear_q <= req.clear_pos;
						sum_q   <= req.wheel_sum;
						cnt_q   <= '0;
						state_q <= S_ROT;
					end
				end
				S_ROT: begin
					if (!z_q[31]) begin
						x_q <= x_q - sy;
						y_q <= y_q + sx;
						z_q <= z_q - $signed(ATAN_TAB[cnt_q]);
					end else begin
						x_q <= x_q + sy;
						y_q <= y_q - sx;
						z_q <= z_q + $signed(ATAN_TAB[cnt_q]);
					end
					// The step distance is formed alongside the rotation.
					if (cnt_q == 4'd0) begin
						prod1_q <= p1;
					end
					if (cnt_q == 4'd1) begin
						d_q <= p2[48:8];
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'(CORDIC_ITERS - 1)) begin
						state_q <= S_RND;
					end
				end
				S_RND: begin
					c_q     <= c_new;
					s_q     <= s_new;
					state_q <= S_MULX;
				end
				S_MULX: begin
					pl_q    <= pl;
					ph_q    <= ph;
					state_q <= S_MULY;
				end
				S_MULY: begin
					dx_q    <= delta;
					pl_q    <= pl;
					ph_q    <= ph;
					state_q <= S_DELY;
				end
				S_DELY: begin
					dy_q    <= delta;
					new_x_q <= sat_x;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (commit) begin
						pos_x_q     <= new_x_q;
						pos_y_q     <= sat_y;
						seq_q       <= seq_q + 32'd1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign sequence_res = seq_q;

	a_rot_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROT && cnt_q == 4'(CORDIC_ITERS - 1)) |=> state_q == S_RND)
		else $error("rotation did not end after the last iteration");
	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MULX) |-> (c_q <= 17'sd32770 && c_q >= -17'sd32770
		&& s_q <= 17'sd32770 && s_q >= -17'sd32770))
		else $error("sine or cosine out of range");
	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> seq_q == $past(seq_q) + 32'd1)
		else $error("step count did not advance by one");

endmodule

`default_nettype wire

[src/diff_drive_dead_reckoning_unit.sv]
// A request passes the queue, then the rotate, round, two multiply, delay and done states.
// One tick at a time is finished, set by the 16-iteration shared CORDIC rotator.
// A two-entry request queue lets ticks be accepted while the back part is busy.
// Reset clears position, step count, run state, queue and output valid;
// wheel_radius resets to 4494 and step_size to 6554.
`default_nettype none

module diff_drive_dead_reckoning_unit #(
	parameter int ANGLE_BITS = ddr_pkg::ANGLE_BITS_DEFAULT,
	parameter int FIFO_DEPTH = ddr_pkg::FIFO_DEPTH_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] left_wheel_rate,
	input  wire logic signed [15:0] right_wheel_rate,
	input  wire logic [15:0]        heading,
	input  wire logic               run_flag,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic [31:0]             sequence_res
);
	import ddr_pkg::*;

	logic [15:0] wheel_radius_q;
	logic [15:0] step_size_q;
	logic        push, pop, queue_full, queue_empty;
	ddr_req_t    req_in, req_out;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_radius_q <= RADIUS_RESET;
			step_size_q    <= STEP_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_WHEEL_RADIUS: wheel_radius_q <= pwdata[15:0];
				REG_STEP_SIZE:    step_size_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WHEEL_RADIUS: prdata = {16'h0000, wheel_radius_q};
			REG_STEP_SIZE:    prdata = {16'h0000, step_size_q};
			default:          prdata = '0;
		endcase
	end

	ddr_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.left_wheel_rate  (left_wheel_rate),
		.right_wheel_rate (right_wheel_rate),
		.heading          (heading),
		.run_flag         (run_flag),
		.queue_full       (queue_full),
		.push             (push),
		.req              (req_in)
	);

	ddr_fifo #(
		.WIDTH ($bits(ddr_req_t)),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (req_in),
		.pop       (pop),
		.pop_data  (req_out),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	ddr_back #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_out),
		.req_avail    (!queue_empty),
		.req_pop      (pop),
		.wheel_radius (wheel_radius_q),
		.step_size    (step_size_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.sequence_res (sequence_res)
	);

endmodule

`default_nettype wire
